### hdl/ctb_pkg.sv
`default_nettype none

package ctb_pkg;

    // Fixed limits of the block
    localparam int MAX_TILE_SIZE = 64;
    localparam int ADDRESS_BITS  = 24;
    localparam int MAX_ROWS      = 64;

    // Addresses wrap at ADDRESS_BITS and are carried on 24-bit fields
    localparam logic [23:0] ADDR_MASK = (ADDRESS_BITS >= 24) ? 24'hFF_FFFF
                                        : 24'((64'd1 << ADDRESS_BITS) - 64'd1);

    // Register map, word index on the APB port
    typedef enum logic [2:0] {
        REG_TILE_WIDTH    = 3'd0,
        REG_TILE_HEIGHT   = 3'd1,
        REG_SCREEN_WIDTH  = 3'd2,
        REG_SCREEN_HEIGHT = 3'd3,
        REG_SCREEN_PITCH  = 3'd4,
        REG_SHEET_PITCH   = 3'd5,
        REG_ORIGIN_X      = 3'd6,
        REG_ORIGIN_Y      = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [6:0]         tile_width;
        logic [6:0]         tile_height;
        logic [12:0]        screen_width;
        logic [12:0]        screen_height;
        logic [13:0]        screen_pitch;
        logic [13:0]        sheet_pitch;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
    } cfg_t;

    typedef struct packed {
        logic [7:0] sheet_col;
        logic [7:0] sheet_row;
        logic [9:0] map_col;
        logic [9:0] map_row;
    } req_t;

    typedef struct packed {
        logic [23:0] dst_address;
        logic [23:0] src_address;
        logic [6:0]  row_length;
        logic        last_row;
    } cmd_t;

    // Clipped span handed from the setup pipeline to the row generator
    typedef struct packed {
        logic [12:0] dst_x;
        logic [23:0] dst_row_off;
        logic [15:0] src_x;
        logic [23:0] src_row_off;
        logic [6:0]  width;
        logic [6:0]  rows;
    } span_t;

    function automatic logic [6:0] clamp_size(input logic [6:0] v);
        return (v > 7'(MAX_TILE_SIZE)) ? 7'(MAX_TILE_SIZE) : v;
    endfunction

endpackage

`default_nettype wire

### hdl/ctb_setup.sv
`default_nettype none

module ctb_setup
    import ctb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  req_valid,
    output logic       req_stall,
    input  wire req_t  req,
    output logic       span_valid,
    input  wire logic  span_ready,
    output span_t      span
);

    logic [6:0] tw;
    logic [6:0] th;
    logic       size_zero;

    assign tw = clamp_size(cfg.tile_width);
    assign th = clamp_size(cfg.tile_height);
    assign size_zero = (tw == '0) || (th == '0) ||
                       (cfg.screen_width == '0) || (cfg.screen_height == '0);

    // Stage valids and per-stage ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !v5_reg || span_ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign req_stall = !rdy1;

    // Stage 1: products of cell indices and tile size
    logic [16:0] px_reg, py_reg, px_next, py_next;
    logic [15:0] s1_sx_reg, s1_sy_reg, s1_sx_next, s1_sy_next;
    logic        zero1_reg;

    assign px_next    = 17'(req.map_col * tw);
    assign py_next    = 17'(req.map_row * th);
    assign s1_sx_next = 16'(req.sheet_col * ({1'b0, tw} + 8'd1));
    assign s1_sy_next = 16'(req.sheet_row * ({1'b0, th} + 8'd1));

    // Stage 2: screen position of the tile
    logic signed [19:0] dx_reg, dy_reg, dx_next, dy_next;
    logic [15:0]        s2_sx_reg, s2_sy_reg;
    logic               zero2_reg;

    assign dx_next = $signed({{4{cfg.origin_x[15]}}, cfg.origin_x}) + $signed({3'b0, px_reg});
    assign dy_next = $signed({{4{cfg.origin_y[15]}}, cfg.origin_y}) + $signed({3'b0, py_reg});

    // Stage 3: hidden test and clip amounts on each edge
    logic signed [19:0] dxe, dye, dxr, dyr, ndx, ndy;
    logic               hide_next;
    logic [6:0]         cl_next, ct_next, cr_next, cb_next;
    logic [12:0]        dxc_next, dyc_next;
    logic [6:0]         cl_reg, ct_reg, cr_reg, cb_reg;
    logic [12:0]        s3_dxc_reg, s3_dyc_reg;
    logic [15:0]        s3_sx_reg, s3_sy_reg;
    logic               drop3_reg;

    assign dxe = dx_reg + $signed({13'b0, tw});
    assign dye = dy_reg + $signed({13'b0, th});
    assign dxr = dxe - $signed({7'b0, cfg.screen_width});
    assign dyr = dye - $signed({7'b0, cfg.screen_height});
    assign ndx = -dx_reg;
    assign ndy = -dy_reg;

    assign hide_next = zero2_reg ||
                       (dxe <= 20'sd0) || (dx_reg >= $signed({7'b0, cfg.screen_width})) ||
                       (dye <= 20'sd0) || (dy_reg >= $signed({7'b0, cfg.screen_height}));
    assign cl_next  = dx_reg[19] ? ndx[6:0] : '0;
    assign ct_next  = dy_reg[19] ? ndy[6:0] : '0;
    assign cr_next  = (dxr > 20'sd0) ? dxr[6:0] : '0;
    assign cb_next  = (dyr > 20'sd0) ? dyr[6:0] : '0;
    assign dxc_next = dx_reg[19] ? '0 : dx_reg[12:0];
    assign dyc_next = dy_reg[19] ? '0 : dy_reg[12:0];

    // Stage 4: visible width and rows, source start in the sheet
    logic signed [8:0] wd, hd;
    logic              drop4;
    logic [6:0]        w_next, h_next;
    logic [15:0]       sx_next, sy_next;
    logic [6:0]        w4_reg, h4_reg;
    logic [15:0]       s4_sx_reg, s4_sy_reg;
    logic [12:0]       s4_dxc_reg, s4_dyc_reg;
    logic              drop4_reg;

    assign wd = $signed({2'b0, tw}) - $signed({2'b0, cl_reg}) - $signed({2'b0, cr_reg});
    assign hd = $signed({2'b0, th}) - $signed({2'b0, ct_reg}) - $signed({2'b0, cb_reg});
    assign drop4   = drop3_reg || (wd <= 9'sd0) || (hd <= 9'sd0);
    assign w_next  = wd[6:0];
    assign h_next  = (hd > $signed(9'(MAX_ROWS))) ? 7'(MAX_ROWS) : hd[6:0];
    assign sx_next = s3_sx_reg + 16'd1 + {9'b0, cl_reg};
    assign sy_next = s3_sy_reg + 16'd1 + {9'b0, ct_reg};

    // Stage 5: row offsets of the first visible row
    logic [26:0] dprod;
    logic [29:0] sprod;
    span_t       span_reg, span_next;

    assign dprod = s4_dyc_reg * cfg.screen_pitch;
    assign sprod = s4_sy_reg * cfg.sheet_pitch;

    always_comb
    begin
        span_next.dst_x       = s4_dxc_reg;
        span_next.dst_row_off = dprod[23:0];
        span_next.src_x       = s4_sx_reg;
        span_next.src_row_off = sprod[23:0];
        span_next.width       = w4_reg;
        span_next.rows        = h4_reg;
    end

    // Valid bits; a dropped tile leaves stage 4 without reaching the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= req_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg && !drop4_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            px_reg    <= px_next;
            py_reg    <= py_next;
            s1_sx_reg <= s1_sx_next;
            s1_sy_reg <= s1_sy_next;
            zero1_reg <= size_zero;
        end
        if (rdy2)
        begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            s2_sx_reg <= s1_sx_reg;
            s2_sy_reg <= s1_sy_reg;
            zero2_reg <= zero1_reg;
        end
        if (rdy3)
        begin
            cl_reg     <= cl_next;
            ct_reg     <= ct_next;
            cr_reg     <= cr_next;
            cb_reg     <= cb_next;
            s3_dxc_reg <= dxc_next;
            s3_dyc_reg <= dyc_next;
            s3_sx_reg  <= s2_sx_reg;
            s3_sy_reg  <= s2_sy_reg;
            drop3_reg  <= hide_next;
        end
        if (rdy4)
        begin
            w4_reg     <= w_next;
            h4_reg     <= h_next;
            s4_sx_reg  <= sx_next;
            s4_sy_reg  <= sy_next;
            s4_dxc_reg <= s3_dxc_reg;
            s4_dyc_reg <= s3_dyc_reg;
            drop4_reg  <= drop4;
        end
        if (rdy5)
        begin
            span_reg <= span_next;
        end
    end

    assign span_valid = v5_reg;
    assign span       = span_reg;

endmodule

`default_nettype wire

### hdl/ctb_row_gen.sv
`default_nettype none

module ctb_row_gen
    import ctb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  span_valid,
    output logic       span_ready,
    input  wire span_t span,
    output logic       cmd_valid,
    input  wire logic  cmd_stall,
    output cmd_t       cmd
);

    logic        active_reg, active_next;
    logic [6:0]  rem_reg, rem_next;
    logic [23:0] dst_reg, dst_next;
    logic [23:0] src_reg, src_next;
    logic [6:0]  len_reg, len_next;
    logic        out_valid_reg, out_valid_next;
    cmd_t        out_reg, out_next;

    logic out_free;
    logic emit;
    logic load;

    // Output register frees when empty or when its row is taken
    assign out_free   = !out_valid_reg || !cmd_stall;
    assign emit       = active_reg && out_free;
    assign span_ready = !active_reg || (emit && (rem_reg == 7'd1));
    assign load       = span_valid && span_ready;

    // Walk the rows: one command per cycle while the output register is free, addresses step by the pitches
    always_comb
    begin
        active_next    = active_reg;
        rem_next       = rem_reg;
        dst_next       = dst_reg;
        src_next       = src_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && cmd_stall;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next       = 1'b1;
            out_next.dst_address = dst_reg & ADDR_MASK;
            out_next.src_address = src_reg & ADDR_MASK;
            out_next.row_length  = len_reg;
            out_next.last_row    = (rem_reg == 7'd1);
            dst_next             = dst_reg + {10'b0, cfg.screen_pitch};
            src_next             = src_reg + {10'b0, cfg.sheet_pitch};
            rem_next             = rem_reg - 7'd1;
            active_next          = (rem_reg != 7'd1);
        end
        if (load)
        begin
            active_next = 1'b1;
            rem_next    = span.rows;
            len_next    = span.width;
            dst_next    = span.dst_row_off + {11'b0, span.dst_x};
            src_next    = span.src_row_off + {8'b0, span.src_x};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dst_reg <= dst_next;
        src_reg <= src_next;
        len_reg <= len_next;
        out_reg <= out_next;
    end

    assign cmd_valid = out_valid_reg;
    assign cmd       = out_reg;

`ifndef SYNTHESIS
    // A busy walker always has rows left
    a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (rem_reg != 7'd0))
        else $error("row walker active with no rows left");

    // Once a row that is not the last is taken, the next row follows at once
    a_rows_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && !cmd.last_row) |=> cmd_valid)
        else $error("gap between rows of one tile");

    // Clipped rows are never empty nor longer than a tile
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> ((cmd.row_length != 7'd0) && (cmd.row_length <= 7'(MAX_TILE_SIZE))))
        else $error("row length out of range");

    // A new tile is only loaded while no rows of the previous one are pending
    a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!active_reg || (rem_reg == 7'd1)))
        else $error("tile loaded over unfinished rows");
`endif

endmodule

`default_nettype wire

### hdl/clipped_tile_blit_row_generator.sv
// Channel  | Signals                       | Direction | Transaction
// ---------+-------------------------------+-----------+-------------------------------
// req      | req_valid, req_stall, req     | in        | one tile draw request
// cmd      | cmd_valid, cmd_stall, cmd     | out       | one row-copy command
// apb      | psel, penable, pwrite, paddr, | in/out    | register write or read,
//          | pwdata, prdata, pready        |           | pready always high
//
// A visible tile gives one command per cycle while cmd_stall is low, so it occupies
// the row walker for one command per visible row (1..64); a hidden tile is dropped
// in the setup stages. The first command passes four further setup stages after the
// request is taken, then the row walker load and the output register.
// Reset clears valids and restores register defaults.
// cmd_stall holds the output register and backs up through the setup stages.
`default_nettype none

module clipped_tile_blit_row_generator
    import ctb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire req_t        req,
    output logic             cmd_valid,
    input  wire logic        cmd_stall,
    output cmd_t             cmd,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tile_width    <= 7'd16;
            cfg_reg.tile_height   <= 7'd16;
            cfg_reg.screen_width  <= 13'd800;
            cfg_reg.screen_height <= 13'd512;
            cfg_reg.screen_pitch  <= 14'd800;
            cfg_reg.sheet_pitch   <= 14'd1024;
            cfg_reg.origin_x      <= 16'sd0;
            cfg_reg.origin_y      <= 16'sd0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_TILE_WIDTH:    cfg_reg.tile_width    <= pwdata[6:0];
                REG_TILE_HEIGHT:   cfg_reg.tile_height   <= pwdata[6:0];
                REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= pwdata[12:0];
                REG_SCREEN_HEIGHT: cfg_reg.screen_height <= pwdata[12:0];
                REG_SCREEN_PITCH:  cfg_reg.screen_pitch  <= pwdata[13:0];
                REG_SHEET_PITCH:   cfg_reg.sheet_pitch   <= pwdata[13:0];
                REG_ORIGIN_X:      cfg_reg.origin_x      <= pwdata[15:0];
                REG_ORIGIN_Y:      cfg_reg.origin_y      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_idx)
            REG_TILE_WIDTH:    prdata = {25'b0, cfg_reg.tile_width};
            REG_TILE_HEIGHT:   prdata = {25'b0, cfg_reg.tile_height};
            REG_SCREEN_WIDTH:  prdata = {19'b0, cfg_reg.screen_width};
            REG_SCREEN_HEIGHT: prdata = {19'b0, cfg_reg.screen_height};
            REG_SCREEN_PITCH:  prdata = {18'b0, cfg_reg.screen_pitch};
            REG_SHEET_PITCH:   prdata = {18'b0, cfg_reg.sheet_pitch};
            REG_ORIGIN_X:      prdata = {16'b0, cfg_reg.origin_x};
            REG_ORIGIN_Y:      prdata = {16'b0, cfg_reg.origin_y};
            default:           prdata = '0;
        endcase
    end

    logic  span_valid;
    logic  span_ready;
    span_t span;

    ctb_setup u_setup (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .span_valid (span_valid),
        .span_ready (span_ready),
        .span       (span)
    );

    ctb_row_gen u_row_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .span_valid (span_valid),
        .span_ready (span_ready),
        .span       (span),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd)
    );

endmodule

`default_nettype wire

### verif/clipped_tile_blit_row_generator_test.sv
`timescale 1ns / 100ps

module clipped_tile_blit_row_generator_test
    import ctb_pkg::*;
;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 9;
    localparam int SETTLE_CYCLES   = 24;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 57;
    localparam int REPORT_LIMIT    = 10;

    // Expected row commands, worked out from each accepted draw request
    class blit_row_ledger;
        cfg_t        regs;
        cmd_t        pending_rows[$];
        int unsigned failures;

        function new();
            regs.tile_width    = 7'd16;
            regs.tile_height   = 7'd16;
            regs.screen_width  = 13'd800;
            regs.screen_height = 13'd512;
            regs.screen_pitch  = 14'd800;
            regs.sheet_pitch   = 14'd1024;
            regs.origin_x      = 16'sd0;
            regs.origin_y      = 16'sd0;
            failures           = 0;
        endfunction

        function void write_register(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_TILE_WIDTH:    regs.tile_width    = value[6:0];
                REG_TILE_HEIGHT:   regs.tile_height   = value[6:0];
                REG_SCREEN_WIDTH:  regs.screen_width  = value[12:0];
                REG_SCREEN_HEIGHT: regs.screen_height = value[12:0];
                REG_SCREEN_PITCH:  regs.screen_pitch  = value[13:0];
                REG_SHEET_PITCH:   regs.sheet_pitch   = value[13:0];
                REG_ORIGIN_X:      regs.origin_x      = value[15:0];
                REG_ORIGIN_Y:      regs.origin_y      = value[15:0];
                default:           ;
            endcase
        endfunction

        // Place, clip and split one tile into row copies; returns the row count
        function int note_request(req_t r);
            longint tw, th, sw, sh, dx, dy, cl, ct, cr, cb, w, h, sx, sy, k;
            cmd_t   c;
            tw = (regs.tile_width > MAX_TILE_SIZE) ? MAX_TILE_SIZE : regs.tile_width;
            th = (regs.tile_height > MAX_TILE_SIZE) ? MAX_TILE_SIZE : regs.tile_height;
            sw = regs.screen_width;
            sh = regs.screen_height;
            if (tw == 0 || th == 0 || sw == 0 || sh == 0)
                return 0;
            dx = $signed(regs.origin_x);
            dy = $signed(regs.origin_y);
            dx = dx + longint'(r.map_col) * tw;
            dy = dy + longint'(r.map_row) * th;
            // a tile ending exactly on the left or top edge is hidden
            if (dx + tw <= 0 || dx >= sw || dy + th <= 0 || dy >= sh)
                return 0;
            cl = (dx < 0) ? -dx : 0;
            ct = (dy < 0) ? -dy : 0;
            cr = (dx + tw - sw > 0) ? dx + tw - sw : 0;
            cb = (dy + th - sh > 0) ? dy + th - sh : 0;
            w = tw - cl - cr;
            h = th - ct - cb;
            if (h > MAX_ROWS)
                h = MAX_ROWS;
            if (w <= 0 || h <= 0)
                return 0;
            dx = dx + cl;
            dy = dy + ct;
            sx = longint'(r.sheet_col) * (tw + 1) + 1 + cl;
            sy = longint'(r.sheet_row) * (th + 1) + 1 + ct;
            for (k = 0; k < h; k++)
            begin
                c.dst_address = 24'(dx + (dy + k) * longint'(regs.screen_pitch)) & ADDR_MASK;
                c.src_address = 24'(sx + (sy + k) * longint'(regs.sheet_pitch)) & ADDR_MASK;
                c.row_length  = 7'(w);
                c.last_row    = (k == h - 1);
                pending_rows.push_back(c);
            end
            return int'(h);
        endfunction

        function void check_command(cmd_t got);
            cmd_t want;
            if (pending_rows.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected row command: dst=%h src=%h len=%0d last=%0b",
                             got.dst_address, got.src_address, got.row_length, got.last_row);
                return;
            end
            want = pending_rows.pop_front();
            if (got.dst_address !== want.dst_address || got.src_address !== want.src_address ||
                got.row_length !== want.row_length || got.last_row !== want.last_row)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display({"row command mismatch: exp dst=%h src=%h len=%0d last=%0b,",
                              " got dst=%h src=%h len=%0d last=%0b"},
                             want.dst_address, want.src_address, want.row_length,
                             want.last_row, got.dst_address, got.src_address,
                             got.row_length, got.last_row);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        cmd_valid;
    logic        cmd_stall;
    cmd_t        cmd;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    blit_row_ledger ledger;
    int             burst_left;
    logic           hold_off_due;
    int unsigned    cycle_count;

    clipped_tile_blit_row_generator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Check every accepted row command
    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && !cmd_stall)
            ledger.check_command(cmd);
    end

    // Command sink: stall pattern in stretches, plus one long hold-off on request
    initial
    begin : cmd_sink
        int   mode;
        int   stretch;
        logic hold_off_done;
        cmd_stall     = 1'b0;
        hold_off_done = 1'b0;
        forever
        begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(5, 60);
            repeat (stretch)
            begin
                @(negedge clk);
                if (hold_off_due && !hold_off_done)
                begin
                    hold_off_done = 1'b1;
                    cmd_stall     = 1'b1;
                    repeat (HOLD_OFF_CYCLES) @(negedge clk);
                end
                case (mode)
                    0:       cmd_stall = 1'b0;
                    1:       cmd_stall = ($urandom_range(0, 3) == 0);
                    2:       cmd_stall = ($urandom_range(0, 3) != 0);
                    default: cmd_stall = ~cmd_stall;
                endcase
            end
        end
    end

    task automatic wait_drained();
        while (ledger.pending_rows.size() != 0)
            @(posedge clk);
        // hidden tiles may still be in the setup stages
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        ledger.write_register(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_setup(input cfg_t c);
        wait_drained();
        apb_write(REG_TILE_WIDTH,    32'(c.tile_width));
        apb_write(REG_TILE_HEIGHT,   32'(c.tile_height));
        apb_write(REG_SCREEN_WIDTH,  32'(c.screen_width));
        apb_write(REG_SCREEN_HEIGHT, 32'(c.screen_height));
        apb_write(REG_SCREEN_PITCH,  32'(c.screen_pitch));
        apb_write(REG_SHEET_PITCH,   32'(c.sheet_pitch));
        apb_write(REG_ORIGIN_X,      {{16{c.origin_x[15]}}, c.origin_x});
        apb_write(REG_ORIGIN_Y,      {{16{c.origin_y[15]}}, c.origin_y});
    endtask

    function automatic cfg_t make_setup(int tw, int th, int sw, int sh, int sp, int shp,
                                        int ox, int oy);
        cfg_t c;
        c.tile_width    = 7'(tw);
        c.tile_height   = 7'(th);
        c.screen_width  = 13'(sw);
        c.screen_height = 13'(sh);
        c.screen_pitch  = 14'(sp);
        c.sheet_pitch   = 14'(shp);
        c.origin_x      = 16'(ox);
        c.origin_y      = 16'(oy);
        return c;
    endfunction

    function automatic logic [6:0] random_tile_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return 7'd0;
        if (pick < 15)
            return 7'($urandom_range(65, 127));
        if (pick < 60)
            return 7'($urandom_range(1, 16));
        return 7'($urandom_range(17, 64));
    endfunction

    function automatic logic [12:0] random_screen_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            return 13'd0;
        if (pick < 45)
            return 13'($urandom_range(1, 256));
        if (pick < 90)
            return 13'($urandom_range(257, 4096));
        return 13'($urandom_range(4097, 8191));
    endfunction

    function automatic logic [15:0] random_origin();
        if ($urandom_range(0, 99) < 70)
            return 16'(int'($urandom_range(0, 400)) - 200);
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic cfg_t random_setup();
        cfg_t c;
        c.tile_width    = random_tile_size();
        c.tile_height   = random_tile_size();
        c.screen_width  = random_screen_size();
        c.screen_height = random_screen_size();
        c.screen_pitch  = 14'($urandom_range(0, 16383));
        c.sheet_pitch   = 14'($urandom_range(0, 16383));
        c.origin_x      = random_origin();
        c.origin_y      = random_origin();
        return c;
    endfunction

    // Map index that lands the tile on screen, where one exists
    function automatic logic [9:0] aim_index(longint origin, longint size, longint extent,
                                             logic [9:0] fallback);
        longint lo, hi, k;
        if (size == 0 || extent - 1 - origin < 0)
            return fallback;
        hi = (extent - 1 - origin) / size;
        k  = -origin - size;
        lo = (k < 0) ? 0 : k / size + 1;
        if (hi > 1023)
            hi = 1023;
        if (lo > hi)
            return fallback;
        case ($urandom_range(0, 3))
            0:       return 10'(lo);
            1:       return 10'(hi);
            default: return 10'(lo + $urandom_range(0, int'(hi - lo)));
        endcase
    endfunction

    function automatic req_t random_request();
        req_t   r;
        longint tw, th;
        r.sheet_col = 8'($urandom_range(0, 255));
        r.sheet_row = 8'($urandom_range(0, 255));
        r.map_col   = 10'($urandom_range(0, 1023));
        r.map_row   = 10'($urandom_range(0, 1023));
        tw = (ledger.regs.tile_width > MAX_TILE_SIZE) ? MAX_TILE_SIZE : ledger.regs.tile_width;
        th = (ledger.regs.tile_height > MAX_TILE_SIZE) ? MAX_TILE_SIZE : ledger.regs.tile_height;
        // mostly tiles that reach the screen, the rest anywhere in the map
        if ($urandom_range(0, 99) < 85)
        begin
            r.map_col = aim_index($signed(ledger.regs.origin_x), tw,
                                  ledger.regs.screen_width, r.map_col);
            r.map_row = aim_index($signed(ledger.regs.origin_y), th,
                                  ledger.regs.screen_height, r.map_row);
        end
        return r;
    endfunction

    function automatic req_t mk(int sc, int sr, int mc, int mr);
        req_t r;
        r.sheet_col = 8'(sc);
        r.sheet_row = 8'(sr);
        r.map_col   = 10'(mc);
        r.map_row   = 10'(mr);
        return r;
    endfunction

    // Burst and gap pacing of the request side
    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 15);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0)
        begin
            @(negedge clk);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_request(input req_t r, output int rows);
        @(negedge clk);
        req_valid = 1'b1;
        req       = r;
        do
            @(posedge clk);
        while (req_stall);
        rows = ledger.note_request(r);
    endtask

    task automatic send_list(input req_t items[$]);
        int rows;
        foreach (items[i])
        begin
            pace();
            send_request(items[i], rows);
        end
        @(negedge clk);
        req_valid = 1'b0;
    endtask

    task automatic random_phase(input int count);
        int   offered;
        int   rows;
        req_t r;
        offered = 0;
        while (offered < count)
        begin
            r = random_request();
            pace();
            send_request(r, rows);
            offered++;
        end
        @(negedge clk);
        req_valid = 1'b0;
    endtask

    // Stimulus
    initial
    begin
        req_t batch[$];
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        burst_left   = 0;
        hold_off_due = 1'b0;
        ledger       = new();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // default geometry: corners, far map cell, right-edge boundary
        apply_setup(make_setup(16, 16, 800, 512, 800, 1024, 0, 0));
        batch = {mk(0, 0, 0, 0), mk(255, 255, 49, 31), mk(255, 255, 1023, 1023),
                 mk(1, 2, 50, 0), mk(7, 3, 10, 5)};
        send_list(batch);

        // tiles ending exactly on the left or top edge stay hidden
        apply_setup(make_setup(16, 10, 100, 60, 100, 300, -32, -20));
        batch = {mk(0, 0, 1, 5), mk(0, 0, 5, 1), mk(3, 4, 2, 2), mk(0, 0, 0, 0)};
        send_list(batch);

        // partial clipping on all four sides
        apply_setup(make_setup(16, 10, 100, 60, 100, 300, -37, -23));
        batch = {mk(1, 1, 2, 2), mk(2, 3, 8, 3), mk(4, 5, 3, 8), mk(255, 255, 8, 8)};
        send_list(batch);

        // oversized tile clamps to 64, widest pitches wrap the addresses
        apply_setup(make_setup(127, 127, 8191, 8191, 16383, 16383, 0, 0));
        batch = {mk(255, 255, 0, 0), mk(0, 0, 127, 127), mk(128, 64, 1, 1)};
        send_list(batch);

        // smallest tile and screen, zero pitches
        apply_setup(make_setup(1, 1, 1, 1, 0, 0, 0, 0));
        batch = {mk(0, 0, 0, 0), mk(255, 255, 0, 0), mk(0, 0, 1, 0)};
        send_list(batch);

        // most negative origin
        apply_setup(make_setup(64, 64, 8191, 8191, 8192, 4096, -32768, -32768));
        batch = {mk(9, 9, 512, 512), mk(0, 0, 1023, 1023)};
        send_list(batch);

        // zero tile width and zero screen give nothing
        apply_setup(make_setup(0, 64, 0, 0, 1, 1, 32767, 32767));
        batch = {mk(0, 0, 0, 0), mk(255, 255, 1023, 1023)};
        send_list(batch);

        apply_setup(make_setup(8, 8, 640, 0, 640, 512, 0, 0));
        batch = {mk(0, 0, 0, 0)};
        send_list(batch);

        // random geometry, mostly on-screen tiles; the long hold-off runs on a
        // geometry that keeps tiles visible so the block is sure to fill up
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 1)
            begin
                apply_setup(make_setup(16, 16, 800, 512, 800, 1024, 0, 0));
                hold_off_due = 1'b1;
            end
            else
                apply_setup(random_setup());
            random_phase(ITEMS_PER_PHASE);
        end

        wait_drained();
        if (ledger.failures == 0 && ledger.pending_rows.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
